FILE: hdl/psoc_pkg.sv
// ----------------------------------------------------------------------------
// psoc_pkg: shared types and constants
// Action codes, register map, reset values and parameter defaults for the
// periodic sphere occupancy counter.
// ----------------------------------------------------------------------------
`default_nettype none

package psoc_pkg;

    localparam int MAX_SPHERES_DEF = 256;
    localparam int COORD_BITS_DEF  = 16;

    localparam int POS_W    = 16;
    localparam int BOX_W    = 17;
    localparam int RAD_W    = 32;
    localparam int NUSE_W   = 9;
    localparam int IDX_W    = 8;
    localparam int ACT_W    = 2;
    localparam int HIT_W    = 9;
    localparam int CNT_W    = 32;
    localparam int SQSUM_W  = 64;
    localparam int FOLD_W   = 17;             // folded per-axis distance
    localparam int SQ_W     = 2 * FOLD_W;     // one axis squared
    localparam int DIST_W   = SQ_W + 2;       // sum of three squares
    localparam int APB_AW   = 4;
    localparam int APB_DW   = 32;

    localparam logic [ACT_W-1:0] ACT_LOAD  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_OFFER = 2'd1;
    localparam logic [ACT_W-1:0] ACT_READ  = 2'd2;

    localparam logic [1:0] REG_BOX  = 2'd0;
    localparam logic [1:0] REG_RAD  = 2'd1;
    localparam logic [1:0] REG_NUSE = 2'd2;

    localparam logic [BOX_W-1:0]  BOX_RST  = 17'd65536;
    localparam logic [RAD_W-1:0]  RAD_RST  = 32'd0;
    localparam logic [NUSE_W-1:0] NUSE_RST = 9'd256;

    typedef struct packed {
        logic [BOX_W-1:0]  box_length;
        logic [RAD_W-1:0]  radius_sq;
        logic [NUSE_W-1:0] spheres_in_use;
    } t_cfg;

    typedef struct packed {
        logic c_we;   // centre write
        logic n_we;   // count write
        logic re;     // read both at rd_addr
    } t_tbl_ctl;

endpackage

`default_nettype wire

FILE: hdl/psoc_apb_regs.sv
// ----------------------------------------------------------------------------
// psoc_apb_regs: configuration registers
// APB-style register file for box length, radius squared and spheres in use.
// ----------------------------------------------------------------------------
`default_nettype none

module psoc_apb_regs (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [psoc_pkg::APB_AW-1:0]   paddr,
    input  wire logic [psoc_pkg::APB_DW-1:0]   pwdata,
    output logic      [psoc_pkg::APB_DW-1:0]   prdata,
    output logic                               pready,
    output psoc_pkg::t_cfg                     o_cfg
);
    import psoc_pkg::*;

    t_cfg       r_cfg;
    logic       wr_en;
    logic [1:0] reg_sel;

    assign reg_sel = paddr[3:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.box_length     <= BOX_RST;
            r_cfg.radius_sq      <= RAD_RST;
            r_cfg.spheres_in_use <= NUSE_RST;
        end else if (wr_en) begin
            case (reg_sel)
                REG_BOX:  r_cfg.box_length     <= pwdata[BOX_W-1:0];
                REG_RAD:  r_cfg.radius_sq      <= pwdata[RAD_W-1:0];
                REG_NUSE: r_cfg.spheres_in_use <= pwdata[NUSE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            REG_BOX:  prdata = APB_DW'(r_cfg.box_length);
            REG_RAD:  prdata = APB_DW'(r_cfg.radius_sq);
            REG_NUSE: prdata = APB_DW'(r_cfg.spheres_in_use);
            default:  prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

FILE: hdl/psoc_axis_sq.sv
// ----------------------------------------------------------------------------
// psoc_axis_sq: shared axis distance unit
// Minimum-image fold of one axis distance followed by a squarer.
// ----------------------------------------------------------------------------
`default_nettype none

module psoc_axis_sq #(
    parameter int CW = 16
) (
    input  wire logic [CW-1:0]                 i_c,
    input  wire logic [CW-1:0]                 i_p,
    input  wire logic [psoc_pkg::BOX_W-1:0]    i_box,
    output logic      [psoc_pkg::SQ_W-1:0]     o_sq
);
    import psoc_pkg::*;

    logic [CW-1:0]             d;
    logic signed [FOLD_W:0]    d_s;
    logic signed [FOLD_W:0]    e_s;
    logic signed [FOLD_W:0]    m_s;
    logic [FOLD_W:0]           m_abs;
    logic [FOLD_W-1:0]         a;

    assign d     = (i_c > i_p) ? (i_c - i_p) : (i_p - i_c);
    assign d_s   = $signed((FOLD_W + 1)'(d));
    assign e_s   = $signed({1'b0, i_box}) - d_s;
    // e can go negative when the coordinates sit beyond the box
    assign m_s   = (d_s > e_s) ? e_s : d_s;
    assign m_abs = m_s[FOLD_W] ? (FOLD_W + 1)'(-m_s) : (FOLD_W + 1)'(m_s);
    assign a     = m_abs[FOLD_W-1:0];
    assign o_sq  = SQ_W'(a) * SQ_W'(a);

endmodule

`default_nettype wire

FILE: hdl/psoc_table.sv
// ----------------------------------------------------------------------------
// psoc_table: sphere table
// Centre memory and hit count memory, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module psoc_table #(
    parameter int DEPTH = 256,
    parameter int CW    = 16,
    parameter int AW    = 8
) (
    input  wire logic                          i_clk,
    input  psoc_pkg::t_tbl_ctl                 i_ctl,
    input  wire logic [AW-1:0]                 i_wr_addr,
    input  wire logic [AW-1:0]                 i_rd_addr,
    input  wire logic [3*CW-1:0]               i_c_wdata,
    input  wire logic [psoc_pkg::CNT_W-1:0]    i_n_wdata,
    output logic      [3*CW-1:0]               o_c_rdata,
    output logic      [psoc_pkg::CNT_W-1:0]    o_n_rdata
);
    import psoc_pkg::*;

    logic [3*CW-1:0]  mem_c [DEPTH];
    logic [CNT_W-1:0] mem_n [DEPTH];
    logic [3*CW-1:0]  r_c_rd;
    logic [CNT_W-1:0] r_n_rd;

    always_ff @(posedge i_clk) begin
        if (i_ctl.c_we) begin
            mem_c[i_wr_addr] <= i_c_wdata;
        end
        if (i_ctl.n_we) begin
            mem_n[i_wr_addr] <= i_n_wdata;
        end
        if (i_ctl.re) begin
            r_c_rd <= mem_c[i_rd_addr];
            r_n_rd <= mem_n[i_rd_addr];
        end
    end

    assign o_c_rdata = r_c_rd;
    assign o_n_rdata = r_n_rd;

endmodule

`default_nettype wire

FILE: hdl/periodic_sphere_occupancy_counter_core.sv
// ----------------------------------------------------------------------------
// periodic_sphere_occupancy_counter_core: counts in spheres, minimum image
// Items: load, read and offer each end in one result; offer walks entries 0 to n-1,
//   n = spheres in use capped at MAX_SPHERES; one item at a time.
// Each sphere entry passes S_AX0, S_AX1, S_AX2, S_CMP, S_UPD on the one shared fold-and-square unit.
// After reset a clearing pass over all MAX_SPHERES entries zeroes the count memory;
//   no item is taken meanwhile, configuration writes are.
// ----------------------------------------------------------------------------
`default_nettype none

module periodic_sphere_occupancy_counter_core #(
    parameter int MAX_SPHERES = psoc_pkg::MAX_SPHERES_DEF,
    parameter int COORD_BITS  = psoc_pkg::COORD_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // config
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [psoc_pkg::APB_AW-1:0]   paddr,
    input  wire logic [psoc_pkg::APB_DW-1:0]   pwdata,
    output logic      [psoc_pkg::APB_DW-1:0]   prdata,
    output logic                               pready,
    // input items
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic [psoc_pkg::ACT_W-1:0]    i_action,
    input  wire logic [psoc_pkg::IDX_W-1:0]    i_sphere_index,
    input  wire logic [psoc_pkg::POS_W-1:0]    i_pos_x,
    input  wire logic [psoc_pkg::POS_W-1:0]    i_pos_y,
    input  wire logic [psoc_pkg::POS_W-1:0]    i_pos_z,
    // result items
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic      [psoc_pkg::HIT_W-1:0]    o_spheres_hit,
    output logic      [psoc_pkg::CNT_W-1:0]    o_entry_count,
    output logic      [psoc_pkg::CNT_W-1:0]    o_total_hits,
    output logic      [psoc_pkg::SQSUM_W-1:0]  o_total_hits_sq
);
    import psoc_pkg::*;

    localparam int CW   = (COORD_BITS < POS_W) ? COORD_BITS : POS_W;
    localparam int AW   = (MAX_SPHERES > 1) ? $clog2(MAX_SPHERES) : 1;
    localparam int CNW  = $clog2(MAX_SPHERES + 1);
    localparam int IXW  = (AW > IDX_W) ? AW : IDX_W;

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_EXEC, S_RDW, S_AX0, S_AX1, S_AX2, S_CMP, S_UPD, S_FIN
    } t_state;

    t_cfg              cfg;
    t_state            r_state;
    t_tbl_ctl          tbl_ctl;
    logic [AW-1:0]     wr_addr;
    logic [AW-1:0]     rd_addr;
    logic [CNT_W-1:0]  n_wdata;
    logic [3*CW-1:0]   c_rdata;
    logic [CNT_W-1:0]  n_rdata;

    logic [ACT_W-1:0]  r_act;
    logic              r_idx_ok;
    logic [AW-1:0]     r_addr;
    logic [CW-1:0]     r_px;
    logic [CW-1:0]     r_py;
    logic [CW-1:0]     r_pz;
    logic [CNW-1:0]    r_i;
    logic [CNW-1:0]    r_n;
    logic [CNW-1:0]    r_hits;
    logic [SQ_W-1:0]   r_sq;
    logic [DIST_W-1:0] r_dist;
    logic              r_hit;
    logic [CNT_W-1:0]  r_sum;
    logic [SQSUM_W-1:0] r_sqsum;
    logic [CNT_W-1:0]  r_entry;

    logic              r_o_valid;
    logic [HIT_W-1:0]  r_o_hits;
    logic [CNT_W-1:0]  r_o_entry;
    logic [CNT_W-1:0]  r_o_sum;
    logic [SQSUM_W-1:0] r_o_sqsum;

    logic              in_acc;
    logic [IXW-1:0]    idx_ext;
    logic              idx_ok;
    logic [CNW-1:0]    n_lim;
    logic [CNW-1:0]    i_next;
    logic [CW-1:0]     ax_c;
    logic [CW-1:0]     ax_p;
    logic [SQ_W-1:0]   ax_sq;
    logic              cnt_full;
    logic [SQSUM_W:0]  sq_add;
    logic              out_free;

    psoc_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    psoc_table #(
        .DEPTH (MAX_SPHERES),
        .CW    (CW),
        .AW    (AW)
    ) u_table (
        .i_clk     (i_clk),
        .i_ctl     (tbl_ctl),
        .i_wr_addr (wr_addr),
        .i_rd_addr (rd_addr),
        .i_c_wdata ({r_pz, r_py, r_px}),
        .i_n_wdata (n_wdata),
        .o_c_rdata (c_rdata),
        .o_n_rdata (n_rdata)
    );

    psoc_axis_sq #(
        .CW (CW)
    ) u_axis (
        .i_c   (ax_c),
        .i_p   (ax_p),
        .i_box (cfg.box_length),
        .o_sq  (ax_sq)
    );

    assign o_in_stall = (r_state != S_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign idx_ext    = IXW'(i_sphere_index);
    assign idx_ok     = (32'(i_sphere_index) < MAX_SPHERES);
    assign out_free   = !r_o_valid || !i_out_stall;
    assign i_next     = r_i + 1'b1;

    assign n_lim = (32'(cfg.spheres_in_use) > MAX_SPHERES) ? CNW'(MAX_SPHERES)
                                                           : CNW'(cfg.spheres_in_use);

    // count update terms; n_rdata holds entry r_i until the next read
    assign cnt_full = (n_rdata == '1);
    assign sq_add   = {1'b0, r_sqsum} + (SQSUM_W + 1)'({n_rdata, 1'b1});

    always_comb begin
        case (r_state)
            S_AX1: begin
                ax_c = c_rdata[2*CW-1:CW];
                ax_p = r_py;
            end
            S_AX2: begin
                ax_c = c_rdata[3*CW-1:2*CW];
                ax_p = r_pz;
            end
            default: begin
                ax_c = c_rdata[CW-1:0];
                ax_p = r_px;
            end
        endcase
    end

    // table port control
    always_comb begin
        tbl_ctl = '0;
        wr_addr = r_i[AW-1:0];
        rd_addr = r_addr;
        n_wdata = '0;
        case (r_state)
            S_CLR: begin
                tbl_ctl.n_we = 1'b1;
            end
            S_EXEC: begin
                wr_addr = r_addr;
                if (r_act == ACT_LOAD) begin
                    tbl_ctl.c_we = r_idx_ok;
                end else if (r_act == ACT_READ) begin
                    tbl_ctl.re = 1'b1;
                end else if (r_act == ACT_OFFER) begin
                    tbl_ctl.re = 1'b1;
                    rd_addr    = '0;
                end
            end
            S_UPD: begin
                tbl_ctl.n_we = r_hit && !cnt_full;
                n_wdata      = n_rdata + 1'b1;
                tbl_ctl.re   = (i_next < r_n);
                rd_addr      = i_next[AW-1:0];
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLR;
            r_i       <= '0;
            r_sum     <= '0;
            r_sqsum   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            // S_FIN sets the next result itself when the output frees up
            if (r_o_valid && !i_out_stall && r_state != S_FIN) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                S_CLR: begin
                    r_i <= i_next;
                    if (r_i == CNW'(MAX_SPHERES - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (in_acc) begin
                        r_act    <= i_action;
                        r_idx_ok <= idx_ok;
                        r_addr   <= idx_ext[AW-1:0];
                        r_px     <= i_pos_x[CW-1:0];
                        r_py     <= i_pos_y[CW-1:0];
                        r_pz     <= i_pos_z[CW-1:0];
                        r_state  <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_hits  <= '0;
                    r_entry <= '0;
                    r_i     <= '0;
                    r_n     <= n_lim;
                    if (r_act == ACT_READ) begin
                        r_state <= S_RDW;
                    end else if (r_act == ACT_OFFER && n_lim != '0) begin
                        r_state <= S_AX0;
                    end else begin
                        r_state <= S_FIN;
                    end
                end
                S_RDW: begin
                    r_entry <= r_idx_ok ? n_rdata : '0;
                    r_state <= S_FIN;
                end
                S_AX0: begin
                    r_sq    <= ax_sq;
                    r_state <= S_AX1;
                end
                S_AX1: begin
                    r_dist  <= DIST_W'(r_sq);
                    r_sq    <= ax_sq;
                    r_state <= S_AX2;
                end
                S_AX2: begin
                    r_dist  <= r_dist + DIST_W'(r_sq);
                    r_sq    <= ax_sq;
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    r_hit   <= ((r_dist + DIST_W'(r_sq)) <= DIST_W'(cfg.radius_sq));
                    r_state <= S_UPD;
                end
                S_UPD: begin
                    if (r_hit) begin
                        r_hits <= r_hits + 1'b1;
                        // a saturated count still counts as a hit
                        if (!cnt_full) begin
                            if (r_sum != '1) begin
                                r_sum <= r_sum + 1'b1;
                            end
                            r_sqsum <= sq_add[SQSUM_W] ? '1 : sq_add[SQSUM_W-1:0];
                        end
                    end
                    r_i <= i_next;
                    if (i_next < r_n) begin
                        r_state <= S_AX0;
                    end else begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (out_free) begin
                        r_o_valid <= 1'b1;
                        r_o_hits  <= HIT_W'(r_hits);
                        r_o_entry <= r_entry;
                        r_o_sum   <= r_sum;
                        r_o_sqsum <= r_sqsum;
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid     = r_o_valid;
    assign o_spheres_hit   = r_o_hits;
    assign o_entry_count   = r_o_entry;
    assign o_total_hits    = r_o_sum;
    assign o_total_hits_sq = r_o_sqsum;

endmodule

`default_nettype wire
